@@ rtl/core/rcs_pkg.sv @@
package rcs_pkg;

   // address width of one range end and one block base
   localparam int ADDR_BITS = 32;
   // prefix length field, holds 0 .. ADDR_BITS
   localparam int CNT_W = 6;
   // address count of a range, holds 1 .. 2**ADDR_BITS
   localparam int REM_W = ADDR_BITS + 1;
   // entries in the queue between front and walker
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   typedef struct packed {
      logic [ADDR_BITS-1:0] range_low;
      logic [ADDR_BITS-1:0] range_high;
   } req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] block_base;
      logic [CNT_W-1:0]     prefix_len;
      logic                 last_block;
   } rsp_type;

   // ordered range as handed to the walker: start address and address count
   typedef struct packed {
      logic [ADDR_BITS-1:0] start_addr;
      logic [REM_W-1:0]     addr_count;
   } work_type;

   // number of trailing zero bits, ADDR_BITS for an all-zero address
   function automatic logic [CNT_W-1:0] trail_zeros(input logic [ADDR_BITS-1:0] v);
      logic [CNT_W-1:0] result;
      result = CNT_W'(ADDR_BITS);
      for (int i = ADDR_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            result = CNT_W'(i);
         end
      end
      return result;
   endfunction

   // index of the highest set bit, 0 for zero
   function automatic logic [CNT_W-1:0] floor_log2(input logic [REM_W-1:0] v);
      logic [CNT_W-1:0] result;
      result = '0;
      for (int i = 0; i < REM_W; i++) begin
         if (v[i]) begin
            result = CNT_W'(i);
         end
      end
      return result;
   endfunction

endpackage

@@ rtl/core/rcs_front.sv @@
module rcs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rcs_pkg::req_type   req_data,
   output logic               work_valid,
   input  logic               work_ready,
   output rcs_pkg::work_type  work_data
);

   logic              valid_ff, valid_in;
   rcs_pkg::work_type data_ff, data_in;
   logic [rcs_pkg::ADDR_BITS-1:0] lo, hi;
   logic              swap;

   // order the two ends
   always_comb begin
      swap = req_data.range_low > req_data.range_high;
      lo   = swap ? req_data.range_high : req_data.range_low;
      hi   = swap ? req_data.range_low  : req_data.range_high;
   end

   assign req_ready  = !valid_ff || work_ready;
   assign work_valid = valid_ff;
   assign work_data  = data_ff;

   // stage register, address count = hi - lo + 1
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (work_ready) begin
         valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         valid_in           = 1'b1;
         data_in.start_addr = lo;
         data_in.addr_count = {1'b0, hi} - {1'b0, lo} + rcs_pkg::REM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

@@ rtl/core/rcs_queue.sv @@
module rcs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  rcs_pkg::work_type  push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output rcs_pkg::work_type  pop_data
);

   rcs_pkg::work_type entry_ff [rcs_pkg::QUEUE_DEPTH];
   logic [rcs_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rcs_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rcs_pkg::QCNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = count_ff != rcs_pkg::QCNT_W'(rcs_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + rcs_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + rcs_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + rcs_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - rcs_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/rcs_walker.sv @@
module rcs_walker (
   input  logic               clock,
   input  logic               reset,
   input  logic               work_valid,
   output logic               work_ready,
   input  rcs_pkg::work_type  work_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rcs_pkg::rsp_type   rsp_data
);

   logic                          busy_ff, busy_in;
   logic [rcs_pkg::ADDR_BITS-1:0] cur_ff, cur_in;
   logic [rcs_pkg::REM_W-1:0]     rem_ff, rem_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rcs_pkg::rsp_type              rsp_data_ff, rsp_data_in;
   logic [rcs_pkg::CNT_W-1:0]     tz, lg, k;
   logic [rcs_pkg::REM_W-1:0]     step;
   logic                          last, emit;

   assign work_ready = !busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // largest aligned block at the cursor that fits in the remaining count
   always_comb begin
      tz   = rcs_pkg::trail_zeros(cur_ff);
      lg   = rcs_pkg::floor_log2(rem_ff);
      k    = (tz < lg) ? tz : lg;
      step = rcs_pkg::REM_W'(1) << k;
      last = rem_ff == step;
      emit = busy_ff && (!rsp_valid_ff || rsp_ready);
   end

   // load a range, then emit one block per cycle into the output register while it is free or being taken
   always_comb begin
      busy_in      = busy_ff;
      cur_in       = cur_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (!busy_ff) begin
         if (work_valid) begin
            busy_in = 1'b1;
            cur_in  = work_data.start_addr;
            rem_in  = work_data.addr_count;
         end
      end else if (emit) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.block_base = cur_ff;
         rsp_data_in.prefix_len = rcs_pkg::CNT_W'(rcs_pkg::ADDR_BITS) - k;
         rsp_data_in.last_block = last;
         cur_in  = cur_ff + step[rcs_pkg::ADDR_BITS-1:0];
         rem_in  = rem_ff - step;
         busy_in = !last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ rtl/core/ipv4_range_to_cidr_splitter_top.sv @@
// Splits an inclusive IPv4 range (ends in either order) into the minimal
// ascending list of aligned CIDR blocks, one block per rsp transfer, with
// last_block set on the final one. The front stage orders the ends and
// forms the address count, a two-entry queue holds ranges waiting, and the
// walker loads a range while idle and then emits its blocks (1 to 62 per
// range) one at a time; it takes no new range until the last block of the
// current one is emitted, while further ranges are taken into the front
// stage and queue meanwhile. The walker pauses while a block in the rsp
// output register waits to be taken.
module ipv4_range_to_cidr_splitter_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rcs_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rcs_pkg::rsp_type  rsp_data
);

   logic              f_valid, f_ready;
   rcs_pkg::work_type f_data;
   logic              q_valid, q_ready;
   rcs_pkg::work_type q_data;

   // order ends, compute count
   rcs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .work_valid (f_valid),
      .work_ready (f_ready),
      .work_data  (f_data)
   );

   // decoupling queue
   rcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   // block walk
   rcs_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .work_valid (q_valid),
      .work_ready (q_ready),
      .work_data  (q_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
